>>> sv/nlrd_pkg.sv
// Package for the nibble level run decoder.
// Holds the result and decoder state types, codes and the nibble step function.
// No dependencies.
`default_nettype none

package nlrd_pkg;

    localparam int RES_MAX = 3;

    localparam logic [16:0] ACC_MAX  = 17'h1FFFF;
    localparam logic [17:0] NIB_MAX  = 18'h3FFFF;
    localparam logic [16:0] CONS_MAX = 17'h1FFFF;

    typedef enum logic [1:0] {
        PH_HDR_HI = 2'd0,
        PH_HDR_LO = 2'd1,
        PH_BODY   = 2'd2,
        PH_IDLE   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_CAP     = 2'd2,
        ST_RAN_OUT = 2'd3
    } status_t;

    typedef enum logic {
        CFG_INITIAL_LEVEL  = 1'b0,
        CFG_LEVEL_CAPACITY = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [3:0]  level;
        logic [15:0] run_length;
        logic        done_res;
        status_t     status;
        logic [16:0] consumed_bytes;
    } res_t;

    // remaining counts down from the declared total
    typedef struct packed {
        logic [15:0] remaining;
        logic [3:0]  lvl;
        logic [16:0] acc;
        logic        in_rep;
        logic [17:0] nread;
    } body_state_t;

    typedef struct packed {
        body_state_t st;
        logic        emit;
        logic [15:0] len;
    } nib_out_t;

    function automatic nib_out_t nib_step(body_state_t s_in, logic [3:0] nib);
        nib_out_t    o;
        logic [17:0] want;
        o      = '0;
        o.st   = s_in;
        want   = '0;
        if (o.st.nread != NIB_MAX)
            o.st.nread = o.st.nread + 18'd1;
        if (o.st.in_rep)
        begin
            if (o.st.acc[16:14] != 3'd0)
                o.st.acc = ACC_MAX;
            else
                o.st.acc = {o.st.acc[13:0], nib[2:0]};
            if (!nib[3])
            begin
                o.st.in_rep = 1'b0;
                want        = {1'b0, o.st.acc} + 18'd3;
                o.emit      = 1'b1;
                o.st.acc    = '0;
            end
        end
        else if (nib != 4'd0)
        begin
            o.st.lvl = nib;
            want     = 18'd1;
            o.emit   = 1'b1;
        end
        else
        begin
            o.st.in_rep = 1'b1;
            o.st.acc    = '0;
        end
        if (o.emit)
        begin
            o.len          = (want > {2'b00, o.st.remaining}) ? o.st.remaining : want[15:0];
            o.st.remaining = o.st.remaining - o.len;
        end
        return o;
    endfunction

    function automatic logic [16:0] body_consumed(logic [17:0] nread);
        logic [18:0] half;
        logic [18:0] total;
        half  = ({1'b0, nread} + 19'd1) >> 1;
        total = half + 19'd2;
        if (total > {2'b00, CONS_MAX})
            return CONS_MAX;
        return total[16:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/nlrd_core.sv
// Decoder core: phase and body state registers, one byte decoded per beat.
// Produces up to three results per byte. Depends on nlrd_pkg.
`default_nettype none

module nlrd_core
    import nlrd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 first_byte,
    input  wire logic                 final_byte,
    input  wire logic [3:0]           initial_level,
    input  wire logic [15:0]          level_capacity,
    output res_t      [RES_MAX-1:0]   res,
    output logic      [1:0]           res_cnt
);

    phase_t      phase_reg;
    phase_t      phase_next;
    body_state_t st_reg;
    body_state_t st_next;
    nib_out_t    hi_out;
    nib_out_t    lo_out;
    phase_t      ph;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR_HI;
            st_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            st_reg    <= st_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        st_next    = st_reg;
        res        = '0;
        res_cnt    = 2'd0;
        hi_out     = '0;
        lo_out     = '0;
        ph         = phase_reg;
        if (fire)
        begin
            if (first_byte)
                ph = PH_HDR_HI;
            phase_next = ph;
            unique case (ph)
                PH_IDLE:
                begin
                end
                PH_HDR_HI:
                begin
                    st_next.remaining = {data_byte, 8'h00};
                    st_next.acc       = '0;
                    st_next.in_rep    = 1'b0;
                    st_next.nread     = '0;
                    if (final_byte)
                    begin
                        res[0]     = '{st_reg.lvl, 16'd0, 1'b1, ST_SHORT, 17'd1};
                        res_cnt    = 2'd1;
                        phase_next = PH_IDLE;
                    end
                    else
                        phase_next = PH_HDR_LO;
                end
                PH_HDR_LO:
                begin
                    st_next.remaining = {st_reg.remaining[15:8], data_byte};
                    st_next.lvl       = initial_level;
                    phase_next        = PH_IDLE;
                    res_cnt           = 2'd1;
                    priority if (st_next.remaining > level_capacity)
                        res[0] = '{initial_level, 16'd0, 1'b1, ST_CAP, 17'd2};
                    else if (st_next.remaining == 16'd0)
                        res[0] = '{initial_level, 16'd0, 1'b1, ST_OK, 17'd2};
                    else if (final_byte)
                        res[0] = '{initial_level, 16'd0, 1'b1, ST_RAN_OUT, 17'd2};
                    else
                    begin
                        res_cnt    = 2'd0;
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    hi_out  = nib_step(st_reg, data_byte[7:4]);
                    st_next = hi_out.st;
                    if (hi_out.emit)
                    begin
                        res[res_cnt] = '{hi_out.st.lvl, hi_out.len, 1'b0, ST_OK, 17'd0};
                        res_cnt      = res_cnt + 2'd1;
                    end
                    if (hi_out.st.remaining == 16'd0)
                    begin
                        res[res_cnt] = '{hi_out.st.lvl, 16'd0, 1'b1, ST_OK,
                                         body_consumed(hi_out.st.nread)};
                        res_cnt      = res_cnt + 2'd1;
                        phase_next   = PH_IDLE;
                    end
                    else
                    begin
                        lo_out  = nib_step(hi_out.st, data_byte[3:0]);
                        st_next = lo_out.st;
                        if (lo_out.emit)
                        begin
                            res[res_cnt] = '{lo_out.st.lvl, lo_out.len, 1'b0, ST_OK, 17'd0};
                            res_cnt      = res_cnt + 2'd1;
                        end
                        if (lo_out.st.remaining == 16'd0)
                        begin
                            res[res_cnt] = '{lo_out.st.lvl, 16'd0, 1'b1, ST_OK,
                                             body_consumed(lo_out.st.nread)};
                            res_cnt      = res_cnt + 2'd1;
                            phase_next   = PH_IDLE;
                        end
                        else if (final_byte)
                        begin
                            res[res_cnt] = '{lo_out.st.lvl, 16'd0, 1'b1, ST_RAN_OUT,
                                             body_consumed(lo_out.st.nread)};
                            res_cnt      = res_cnt + 2'd1;
                            phase_next   = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    a_body_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> st_reg.remaining != 16'd0)
        else $error("body phase with nothing left to emit");

    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg == PH_IDLE && !first_byte |-> res_cnt == 2'd0)
        else $error("result produced after end of sound");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_cnt == 2'd3 |-> res[2].done_res && !res[0].done_res && !res[1].done_res)
        else $error("final status result not last in beat");

endmodule

`default_nettype wire

>>> sv/nlrd_res_buf.sv
// Result buffer: holds the results of one byte and drains them one per beat.
// Depends on nlrd_pkg.
`default_nettype none

module nlrd_res_buf
    import nlrd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire res_t [RES_MAX-1:0] ld_res,
    input  wire logic [1:0]         ld_cnt,
    output logic                    can_load,
    output logic                    head_valid,
    input  wire logic               head_ready,
    output res_t                    head
);

    res_t [RES_MAX-1:0] slot_reg;
    logic [1:0]         cnt_reg;
    logic               pop;

    assign head_valid = (cnt_reg != 2'd0);
    assign pop        = head_valid && head_ready;
    assign can_load   = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && head_ready);
    assign head       = slot_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (load)
            cnt_reg <= ld_cnt;
        else if (pop)
            cnt_reg <= cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            slot_reg <= ld_res;
        else if (pop)
        begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

endmodule

`default_nettype wire

>>> sv/nibble_level_run_decoder.sv
// Top level of the nibble level run decoder: byte input register, config
// registers, decoder core and result buffer. Depends on nlrd_pkg, nlrd_core, nlrd_res_buf.
//
// Decodes a sound sent as bytes: two header bytes give a big-endian sample
// count, then each body byte carries two nibbles that set a level or encode
// a repeat run. Each result beat is one run (level, run_length) or a final
// status beat with done_res set, status and consumed_bytes. A byte is
// registered when taken, then decoded once the result buffer can load. While
// res_ready is high, a byte giving at most one result sustains one byte per cycle;
// with more (at most three) the next byte waits as the buffer drains one beat per cycle.
// Write initial_level (index 0) and level_capacity (index 1) only while idle.
`default_nettype none

module nibble_level_run_decoder
    import nlrd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        byte_valid,
    output logic             byte_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        first_byte,
    input  wire logic        final_byte,
    output logic             res_valid,
    input  wire logic        res_ready,
    output logic [3:0]       level,
    output logic [15:0]      run_length,
    output logic             done_res,
    output logic [1:0]       status,
    output logic [16:0]      consumed_bytes
);

    logic               byte_valid_reg;
    logic [7:0]         data_reg;
    logic               first_reg;
    logic               final_reg;
    logic [3:0]         init_level_reg;
    logic [15:0]        capacity_reg;
    logic               can_load;
    logic               fire;
    res_t [RES_MAX-1:0] core_res;
    logic [1:0]         core_cnt;
    res_t               head;

    assign cfg_ready  = 1'b1;
    assign fire       = byte_valid_reg && can_load;
    assign byte_ready = !byte_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_level_reg <= 4'd0;
            capacity_reg   <= 16'hFFFF;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_INITIAL_LEVEL:  init_level_reg <= cfg_data[3:0];
                CFG_LEVEL_CAPACITY: capacity_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_valid_reg <= 1'b0;
        else if (byte_ready)
            byte_valid_reg <= byte_valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
        begin
            data_reg  <= data_byte;
            first_reg <= first_byte;
            final_reg <= final_byte;
        end
    end

    nlrd_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .data_byte      (data_reg),
        .first_byte     (first_reg),
        .final_byte     (final_reg),
        .initial_level  (init_level_reg),
        .level_capacity (capacity_reg),
        .res            (core_res),
        .res_cnt        (core_cnt)
    );

    nlrd_res_buf u_res_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .ld_res     (core_res),
        .ld_cnt     (core_cnt),
        .can_load   (can_load),
        .head_valid (res_valid),
        .head_ready (res_ready),
        .head       (head)
    );

    assign level          = head.level;
    assign run_length     = head.run_length;
    assign done_res       = head.done_res;
    assign status         = head.status;
    assign consumed_bytes = head.consumed_bytes;

endmodule

`default_nettype wire

>>> tb/nibble_level_run_decoder_test.sv
// Self-checking testbench for nibble_level_run_decoder: queued byte beats, an
// in-bench decoder predictor and a result checker with random sender and receiver idling.
// Depends on nlrd_pkg and the nibble_level_run_decoder RTL.
`default_nettype none

module nibble_level_run_decoder_test;
    import nlrd_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [7:0] data;
        logic       first;
        logic       fin;
    } byte_item_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_idx_t    cfg_index;
    logic [15:0] cfg_data;
    logic        byte_valid;
    logic        byte_ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        final_byte;
    logic        res_valid;
    logic        res_ready;
    logic [3:0]  level;
    logic [15:0] run_length;
    logic        done_res;
    logic [1:0]  status;
    logic [16:0] consumed_bytes;

    byte_item_t byte_queue[$];
    res_t       expected_beats[$];

    logic [3:0]  cfg_init_level = 4'd0;
    logic [15:0] cfg_capacity = 16'hFFFF;

    phase_t      dec_phase = PH_HDR_HI;
    logic [15:0] dec_declared = '0;
    logic [15:0] dec_emitted = '0;
    logic [3:0]  dec_level = '0;
    logic [16:0] dec_acc = '0;
    logic        dec_in_rep = 1'b0;
    logic [17:0] dec_nibbles = '0;

    bit byte_taken = 1'b0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int stall_timer = 0;
    logic [31:0] stall_pat = '1;

    int fail_count = 0;
    int cycle_count = 0;
    int bytes_taken = 0;
    int beats_checked = 0;
    int settings_used = 1;
    int ends_seen[4] = '{0, 0, 0, 0};

    nibble_level_run_decoder i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void push_result(logic [3:0] lv, logic [15:0] len, logic dn,
                                        status_t st, int cons);
        res_t r;
        r.level          = lv;
        r.run_length     = len;
        r.done_res       = dn;
        r.status         = st;
        r.consumed_bytes = cons[16:0];
        expected_beats.push_back(r);
    endfunction

    function automatic int consumed_so_far();
        int c;
        c = 2 + (int'(dec_nibbles) + 1) / 2;
        return (c > int'(CONS_MAX)) ? int'(CONS_MAX) : c;
    endfunction

    function automatic void close_sound(status_t st, int cons);
        push_result(dec_level, 16'd0, 1'b1, st, cons);
        dec_phase = PH_IDLE;
    endfunction

    function automatic void emit_run(int want);
        int left;
        left = int'(dec_declared) - int'(dec_emitted);
        if (want > left)
            want = left;
        dec_emitted = dec_emitted + want[15:0];
        push_result(dec_level, want[15:0], 1'b0, ST_OK, 0);
    endfunction

    function automatic void decode_nibble(logic [3:0] nib);
        int grown;
        if (dec_nibbles != NIB_MAX)
            dec_nibbles = dec_nibbles + 18'd1;
        if (dec_in_rep)
        begin
            grown = (int'(dec_acc) << 3) | int'(nib[2:0]);
            if (dec_acc > (ACC_MAX >> 3) || grown > int'(ACC_MAX))
                dec_acc = ACC_MAX;
            else
                dec_acc = grown[16:0];
            if (!nib[3])
            begin
                dec_in_rep = 1'b0;
                emit_run(int'(dec_acc) + 3);
                dec_acc = '0;
            end
        end
        else if (nib != 4'd0)
        begin
            dec_level = nib;
            emit_run(1);
        end
        else
        begin
            dec_in_rep = 1'b1;
            dec_acc    = '0;
        end
    endfunction

    function automatic void decode_byte(byte_item_t item);
        if (item.first)
            dec_phase = PH_HDR_HI;
        case (dec_phase)
            PH_HDR_HI:
            begin
                dec_declared = {item.data, 8'h00};
                dec_emitted  = '0;
                dec_acc      = '0;
                dec_in_rep   = 1'b0;
                dec_nibbles  = '0;
                if (item.fin)
                    close_sound(ST_SHORT, 1);
                else
                    dec_phase = PH_HDR_LO;
            end
            PH_HDR_LO:
            begin
                dec_declared[7:0] = item.data;
                dec_level         = cfg_init_level;
                if (dec_declared > cfg_capacity)
                    close_sound(ST_CAP, 2);
                else if (dec_declared == 16'd0)
                    close_sound(ST_OK, 2);
                else if (item.fin)
                    close_sound(ST_RAN_OUT, 2);
                else
                    dec_phase = PH_BODY;
            end
            PH_BODY:
            begin
                decode_nibble(item.data[7:4]);
                if (dec_emitted >= dec_declared)
                    close_sound(ST_OK, consumed_so_far());
                else
                begin
                    decode_nibble(item.data[3:0]);
                    if (dec_emitted >= dec_declared)
                        close_sound(ST_OK, consumed_so_far());
                    else if (item.fin)
                        close_sound(ST_RAN_OUT, consumed_so_far());
                end
            end
            default: ;
        endcase
    endfunction

    // take byte beats and predict their results
    always @(posedge clk)
    begin : take_byte
        byte_item_t item;
        if (rst_n && byte_valid && byte_ready)
        begin
            item.data  = data_byte;
            item.first = first_byte;
            item.fin   = final_byte;
            decode_byte(item);
            bytes_taken++;
            byte_taken <= 1'b1;
        end
        else
            byte_taken <= 1'b0;
    end

    // feed byte beats in bursts, holding each until taken
    always @(negedge clk)
    begin : drive_byte
        byte_item_t item;
        if (rst_n && (!byte_valid || byte_taken))
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap_left > 0 || byte_queue.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                byte_valid <= 1'b0;
            end
            else
            begin
                item = byte_queue.pop_front();
                byte_valid <= 1'b1;
                data_byte  <= item.data;
                first_byte <= item.first;
                final_byte <= item.fin;
                burst_left--;
            end
        end
    end

    always @(negedge clk)
    begin : drive_ready
        if (stall_timer == 0)
        begin
            stall_mode  = $urandom_range(0, 2);
            stall_pat   = $urandom | 32'd1;
            stall_timer = $urandom_range(20, 80);
        end
        else
            stall_timer--;
        case (stall_mode)
            0: res_ready <= 1'b1;
            1:
            begin
                res_ready <= stall_pat[0];
                stall_pat = {stall_pat[0], stall_pat[31:1]};
            end
            default: res_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin : check_result
        res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("unexpected result beat: level %0d run_length %0d done_res %0d",
                       level, run_length, done_res);
                fail_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                beats_checked++;
                if (level !== want.level)
                begin
                    $error("level: expected %0d, got %0d", want.level, level);
                    fail_count++;
                end
                if (run_length !== want.run_length)
                begin
                    $error("run_length: expected %0d, got %0d", want.run_length, run_length);
                    fail_count++;
                end
                if (done_res !== want.done_res)
                begin
                    $error("done_res: expected %0d, got %0d", want.done_res, done_res);
                    fail_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fail_count++;
                end
                if (consumed_bytes !== want.consumed_bytes)
                begin
                    $error("consumed_bytes: expected %0d, got %0d",
                           want.consumed_bytes, consumed_bytes);
                    fail_count++;
                end
                if (want.done_res)
                    ends_seen[want.status]++;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_byte(logic [7:0] data, logic first, logic fin);
        byte_item_t item;
        item.data  = data;
        item.first = first;
        item.fin   = fin;
        byte_queue.push_back(item);
    endtask

    task automatic add_sound(logic [15:0] count, int n_nib, bit mark_final);
        logic [3:0] nibs[$];
        int groups;
        while (nibs.size() < n_nib)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                nibs.push_back(4'h0);
                groups = ($urandom_range(0, 19) == 0) ? $urandom_range(3, 8)
                                                       : $urandom_range(1, 2);
                for (int g = 0; g < groups; g++)
                    nibs.push_back({g < groups - 1, 3'($urandom_range(0, 7))});
            end
            else
                nibs.push_back(4'($urandom_range(1, 15)));
        end
        if (nibs.size() % 2 != 0)
            nibs.push_back(4'($urandom));
        queue_byte(count[15:8], 1'b1, 1'b0);
        queue_byte(count[7:0], 1'b0, 1'b0);
        for (int i = 0; i < nibs.size(); i += 2)
            queue_byte({nibs[i], nibs[i + 1]}, 1'b0, mark_final && (i + 2 == nibs.size()));
    endtask

    task automatic random_sounds(int n_bytes);
        int goal;
        int pick;
        goal = byte_queue.size() + n_bytes;
        while (byte_queue.size() < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                repeat ($urandom_range(1, 5))
                    queue_byte(8'($urandom), $urandom_range(0, 3) == 0,
                               $urandom_range(0, 3) == 0);
            end
            else if (pick < 14)
                add_sound(16'd0, 1, $urandom_range(0, 1));
            else if (pick < 22)
                add_sound(16'($urandom), $urandom_range(1, 24), $urandom_range(0, 9) < 7);
            else
                add_sound(16'($urandom_range(1, 120)), $urandom_range(1, 24),
                          $urandom_range(0, 9) < 7);
        end
    endtask

    task automatic set_register(cfg_idx_t idx, logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_INITIAL_LEVEL)
            cfg_init_level = value[3:0];
        else
            cfg_capacity = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (byte_queue.size() != 0 || byte_valid || expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [3:0]  levels[4];
        logic [15:0] capacities[4];
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_INITIAL_LEVEL;
        cfg_data   = '0;
        byte_valid = 1'b0;
        data_byte  = '0;
        first_byte = 1'b0;
        final_byte = 1'b0;
        res_ready  = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // header without a start mark straight after reset, early end on a high nibble
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'h03, 1'b0, 1'b0);
        queue_byte(8'h5F, 1'b0, 1'b0);
        queue_byte(8'h70, 1'b0, 1'b1);
        queue_byte(8'hAB, 1'b0, 1'b0);
        queue_byte(8'h12, 1'b1, 1'b1);
        queue_byte(8'h00, 1'b1, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b1);
        queue_byte(8'h00, 1'b1, 1'b0);
        queue_byte(8'h05, 1'b0, 1'b1);
        // saturating repeat count cut at the full declared total
        queue_byte(8'hFF, 1'b1, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b0);
        queue_byte(8'h0F, 1'b0, 1'b0);
        repeat (4) queue_byte(8'hFF, 1'b0, 1'b0);
        queue_byte(8'hF7, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b1, 1'b0);
        queue_byte(8'h04, 1'b0, 1'b0);
        queue_byte(8'h0A, 1'b0, 1'b1);
        wait_idle();

        set_register(CFG_INITIAL_LEVEL, 16'd15);
        set_register(CFG_LEVEL_CAPACITY, 16'd0);
        settings_used++;
        queue_byte(8'h00, 1'b1, 1'b0);
        queue_byte(8'h01, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b1, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b1);
        wait_idle();

        levels     = '{4'd7, 4'd0, 4'd15, 4'($urandom)};
        capacities = '{16'd1000, 16'hFFFF, 16'd40, 16'($urandom_range(60, 65535))};
        for (int p = 0; p < 4; p++)
        begin
            set_register(CFG_INITIAL_LEVEL, {12'd0, levels[p]});
            set_register(CFG_LEVEL_CAPACITY, capacities[p]);
            settings_used++;
            random_sounds(72);
            wait_idle();
        end

        $display("Checked %0d result beats from %0d input bytes over %0d register settings",
                 beats_checked, bytes_taken, settings_used);
        $display("Sound endings: %0d ok, %0d too short, %0d over capacity, %0d ran out",
                 ends_seen[ST_OK], ends_seen[ST_SHORT], ends_seen[ST_CAP],
                 ends_seen[ST_RAN_OUT]);
        if (fail_count == 0 && expected_beats.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
sv/nlrd_pkg.sv
sv/nlrd_core.sv
sv/nlrd_res_buf.sv
sv/nibble_level_run_decoder.sv
tb/nibble_level_run_decoder_test.sv
